### rtl/core/hvt_pkg.sv
// Package with shared constants and codes for the vertex transform unit.
`timescale 1ns / 1ps
package hvt_pkg;
	localparam int HVT_FRAC_BITS = 16;
	localparam int HVT_COORD_W = 32;
	localparam int HVT_SUM_W = 66;
	localparam int HVT_NUM_REGS = 8;
	localparam int HVT_ADDR_W = 6;
	localparam int HVT_DIV_LAT = HVT_COORD_W + 1;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_WZERO = 2'd2;
	localparam logic [31:0] HVT_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] HVT_NEG_MIN = 32'h8000_0000;
endpackage

### rtl/core/hvt_if.sv
// Stream interfaces for input points and transformed results.
`timescale 1ns / 1ps
interface hvt_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] in_x;
	logic signed [31:0] in_y;
	logic signed [31:0] in_z;
	modport source (output valid, in_x, in_y, in_z, input ready);
	modport sink (input valid, in_x, in_y, in_z, output ready);
endinterface

interface hvt_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic [1:0] status;
	modport source (output valid, out_x, out_y, out_z, status, input ready);
	modport sink (input valid, out_x, out_y, out_z, status, output ready);
endinterface

### rtl/core/hvt_mul_sum.sv
// Two pipeline stages: matrix entry products, then exact row sums.
`timescale 1ns / 1ps
module hvt_mul_sum import hvt_pkg::*; #(
	parameter int FRAC_BITS = HVT_FRAC_BITS
) (
	input  logic clk,
	input  logic en,
	input  logic [15:0][31:0] mat,
	input  logic signed [31:0] x,
	input  logic signed [31:0] y,
	input  logic signed [31:0] z,
	output logic [3:0][HVT_SUM_W-1:0] sums
);
	logic signed [63:0] prod_s1 [4][4];
	logic signed [HVT_SUM_W-1:0] sum_s2 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				prod_s1[r][0] <= $signed(mat[r*4+0]) * x;
				prod_s1[r][1] <= $signed(mat[r*4+1]) * y;
				prod_s1[r][2] <= $signed(mat[r*4+2]) * z;
				prod_s1[r][3] <= 64'($signed(mat[r*4+3])) <<< FRAC_BITS;
			end
			for (int r = 0; r < 4; r++) begin
				sum_s2[r] <= HVT_SUM_W'(prod_s1[r][0]) + HVT_SUM_W'(prod_s1[r][1])
					+ HVT_SUM_W'(prod_s1[r][2]) + HVT_SUM_W'(prod_s1[r][3]);
			end
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) sums[r] = sum_s2[r];
	end
endmodule

### rtl/core/hvt_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps
module hvt_div import hvt_pkg::*; #(
	parameter int FRAC_BITS = HVT_FRAC_BITS
) (
	input  logic clk,
	input  logic en,
	input  logic [HVT_SUM_W+FRAC_BITS-1:0] num,
	input  logic [HVT_SUM_W-1:0] den,
	output logic [HVT_COORD_W-1:0] quo,
	output logic ovf
);
	localparam int NW = HVT_SUM_W + FRAC_BITS;
	localparam int QW = HVT_COORD_W;

	logic [HVT_SUM_W-1:0] r_s [QW+1];
	logic [QW-1:0] lo_s [QW+1];
	logic [QW-1:0] q_s [QW+1];
	logic [HVT_SUM_W-1:0] d_s [QW+1];
	logic ovf_s [QW+1];

	// The quotient fits 32 bits only if the top part of the numerator is below the divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= HVT_SUM_W'(num[NW-1:QW]) >= den;
			r_s[0] <= HVT_SUM_W'(num[NW-1:QW]);
			lo_s[0] <= num[QW-1:0];
			q_s[0] <= '0;
			d_s[0] <= den;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_stage
		logic [HVT_SUM_W:0] trial;
		logic [HVT_SUM_W:0] diff;
		logic ge;
		always_comb begin
			trial = {r_s[k-1], lo_s[k-1][QW-1]};
			diff = trial - {1'b0, d_s[k-1]};
			ge = trial >= {1'b0, d_s[k-1]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k] <= ge ? diff[HVT_SUM_W-1:0] : trial[HVT_SUM_W-1:0];
				lo_s[k] <= {lo_s[k-1][QW-2:0], 1'b0};
				q_s[k] <= {q_s[k-1][QW-2:0], ge};
				d_s[k] <= d_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign quo = q_s[QW];
	assign ovf = ovf_s[QW];
endmodule

### rtl/core/homogeneous_vertex_transform_unit.sv
// Top level of the homogeneous 4x4 vertex transform with perspective divide.
`timescale 1ns / 1ps
// Each item is a point (x, y, z) in signed fixed point with FRAC_BITS fraction
// bits. It is extended to (x, y, z, 1), multiplied by the 4x4 row-major matrix
// held in eight 64-bit APB registers (register i at byte address 8*i, entry
// (R,0) or (R,2) in the low word), and the first three row sums are divided by
// the fourth. The block takes one item every clock while not stalled; each
// result passes through 37 register stages: one stage of multipliers, one
// stage of row-sum adders, one stage forming magnitudes and signs, 33 stages
// of the restoring divider (an overflow check followed by one quotient bit
// per stage), and the output register. The whole pipeline advances together
// whenever the output register is empty or its item is being taken, so a
// stall holds every stage in place. Quotients beyond the 32-bit range
// saturate and report status 1; a zero w gives outputs saturated by row-sum
// sign (zero for a zero row sum) and status 2. The matrix resets to identity
// and must only be written while the pipeline is empty.
module homogeneous_vertex_transform_unit import hvt_pkg::*; #(
	parameter int FRAC_BITS = HVT_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [HVT_ADDR_W-1:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	hvt_in_if.sink pt_in,
	hvt_out_if.source pt_out
);
	localparam int NW = HVT_SUM_W + FRAC_BITS;
	localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

	typedef struct packed {
		logic [2:0] neg;
		logic [2:0] sneg;
		logic [2:0] szero;
		logic wz;
	} side_t;

	logic [63:0] mreg_q [HVT_NUM_REGS];
	logic [15:0][31:0] mat;
	logic en;
	logic vld_s1, vld_s2, vld_s3;
	logic vld_dv_s4 [HVT_DIV_LAT];
	side_t side_dv_s4 [HVT_DIV_LAT];
	side_t side_s3;
	logic [3:0][HVT_SUM_W-1:0] sums;
	logic [NW-1:0] num_s3 [3];
	logic [HVT_SUM_W-1:0] den_s3;
	logic [HVT_COORD_W-1:0] quo [3];
	logic ovf [3];
	logic out_vld_q;
	logic [31:0] res_q [3];
	logic [1:0] status_q;
	logic [2:0] idx;

	assign idx = paddr[HVT_ADDR_W-1:3];
	assign pready = 1'b1;
	assign prdata = mreg_q[idx];

	// Matrix registers; reset value is the identity in fixed point.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mreg_q[0] <= ONE;
			mreg_q[1] <= '0;
			mreg_q[2] <= ONE << 32;
			mreg_q[3] <= '0;
			mreg_q[4] <= '0;
			mreg_q[5] <= ONE;
			mreg_q[6] <= '0;
			mreg_q[7] <= ONE << 32;
		end else if (psel && penable && pwrite) begin
			mreg_q[idx] <= pwdata;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				mat[r*4+c] = mreg_q[r*2 + c/2][(c%2)*32 +: 32];
			end
		end
	end

	// The pipeline moves as a whole when the output register can take an item.
	assign en = !out_vld_q || pt_out.ready;
	assign pt_in.ready = en;

	hvt_mul_sum #(.FRAC_BITS(FRAC_BITS)) u_mul_sum (
		.clk  (clk),
		.en   (en),
		.mat  (mat),
		.x    (pt_in.in_x),
		.y    (pt_in.in_y),
		.z    (pt_in.in_z),
		.sums (sums)
	);

	// Stage 3: magnitudes and signs of the row sums and of w.
	always_ff @(posedge clk) begin
		if (en) begin
			den_s3 <= sums[3][HVT_SUM_W-1] ? HVT_SUM_W'(-sums[3]) : sums[3];
			side_s3.wz <= (sums[3] == '0);
			for (int r = 0; r < 3; r++) begin
				num_s3[r] <= NW'(sums[r][HVT_SUM_W-1] ? HVT_SUM_W'(-sums[r]) : sums[r])
					<< FRAC_BITS;
				side_s3.neg[r] <= sums[r][HVT_SUM_W-1] ^ sums[3][HVT_SUM_W-1];
				side_s3.sneg[r] <= sums[r][HVT_SUM_W-1];
				side_s3.szero[r] <= (sums[r] == '0);
			end
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_lane
		hvt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk (clk),
			.en  (en),
			.num (num_s3[r]),
			.den (den_s3),
			.quo (quo[r]),
			.ovf (ovf[r])
		);
	end

	// Sign and zero information travels beside the divider stages.
	always_ff @(posedge clk) begin
		if (en) begin
			side_dv_s4[0] <= side_s3;
			for (int k = 1; k < HVT_DIV_LAT; k++) side_dv_s4[k] <= side_dv_s4[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			for (int k = 0; k < HVT_DIV_LAT; k++) vld_dv_s4[k] <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= pt_in.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_dv_s4[0] <= vld_s3;
			for (int k = 1; k < HVT_DIV_LAT; k++) vld_dv_s4[k] <= vld_dv_s4[k-1];
			out_vld_q <= vld_dv_s4[HVT_DIV_LAT-1];
		end
	end

	// Output stage: apply sign, saturate, and pick the status code.
	always_ff @(posedge clk) begin
		if (en) begin
			logic any_sat;
			side_t sd;
			sd = side_dv_s4[HVT_DIV_LAT-1];
			any_sat = 1'b0;
			for (int r = 0; r < 3; r++) begin
				if (sd.wz) begin
					res_q[r] <= sd.szero[r] ? '0 : (sd.sneg[r] ? HVT_NEG_MIN : HVT_POS_MAX);
				end else if (!sd.neg[r]) begin
					if (ovf[r] || quo[r] > HVT_POS_MAX) begin
						res_q[r] <= HVT_POS_MAX;
						any_sat = 1'b1;
					end else begin
						res_q[r] <= quo[r];
					end
				end else begin
					if (ovf[r] || quo[r] > HVT_NEG_MIN) begin
						res_q[r] <= HVT_NEG_MIN;
						any_sat = 1'b1;
					end else begin
						res_q[r] <= -quo[r];
					end
				end
			end
			status_q <= sd.wz ? ST_WZERO : (any_sat ? ST_SAT : ST_OK);
		end
	end

	assign pt_out.valid = out_vld_q;
	assign pt_out.out_x = res_q[0];
	assign pt_out.out_y = res_q[1];
	assign pt_out.out_z = res_q[2];
	assign pt_out.status = status_q;
endmodule
